// File: rtl/rtc_pkg.sv
// Shared types and constants for the real-time clock block.
// No dependencies; compile first.
package rtc_pkg;

  localparam int CRYSTAL_HZ_DEF = 32768;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    CMD_CRYSTAL_TICK = 2'd0,
    CMD_SECOND_TICK  = 2'd1,
    CMD_CLEAR_STATUS = 2'd2,
    CMD_SET_TIME     = 2'd3
  } rtc_cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLOCK_ENABLE = 2'd0,
    REG_EVENT_MASK   = 2'd1
  } rtc_reg_idx_t;

  localparam logic [15:0] FLAG_SECOND    = 16'h0010;
  localparam logic [15:0] FLAG_MINUTE    = 16'h0002;
  localparam logic [15:0] FLAG_HOUR      = 16'h0020;
  localparam logic [15:0] FLAG_DAY       = 16'h0008;
  localparam logic [15:0] MASK_WRITABLE  = 16'hFF3F;
  localparam logic [15:0] GROUP_PERIODIC = 16'hFF00;
  localparam logic [15:0] GROUP_CLOCK    = 16'h003F;

  localparam int NUM_RATES     = 8;
  localparam int LOWEST_RATE   = 4;
  localparam int SEC_PER_MIN   = 60;
  localparam int MIN_PER_HOUR  = 60;
  localparam int HOURS_PER_DAY = 24;

endpackage

// File: rtl/rtc_if.sv
// Valid/ready channel interfaces for the real-time clock: request input,
// result output and configuration write. Depends on rtc_pkg for widths.
interface rtc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] clear_mask;
  logic [4:0]  new_hours;
  logic [5:0]  new_minutes;
  logic [5:0]  new_seconds;
  logic [8:0]  new_days;

  modport source (output valid, cmd, clear_mask, new_hours, new_minutes,
                  new_seconds, new_days, input ready);
  modport sink   (input valid, cmd, clear_mask, new_hours, new_minutes,
                  new_seconds, new_days, output ready);
endinterface

interface rtc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] event_status;
  logic        periodic_irq;
  logic        clock_irq;
  logic [4:0]  hours_now;
  logic [5:0]  minutes_now;
  logic [5:0]  seconds_now;
  logic [8:0]  days_now;

  modport source (output valid, event_status, periodic_irq, clock_irq,
                  hours_now, minutes_now, seconds_now, days_now, input ready);
  modport sink   (input valid, event_status, periodic_irq, clock_irq,
                  hours_now, minutes_now, seconds_now, days_now, output ready);
endinterface

interface rtc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rtc_pkg::CFG_IDX_W-1:0]  index;
  logic [rtc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/rtc_with_periodic_interrupts_top.sv
// Top level of the real-time clock with periodic interrupts.
// Depends on rtc_pkg and the channel interfaces in rtc_if.sv.
//
// One request is taken every cycle whenever the result side keeps up. It passes
// the input register, then the result register, and the clock state is updated
// as it moves from the first into the second. Crystal ticks drive one phase
// counter per periodic rate, each wrapping at CRYSTAL_HZ/rate and restarted on
// the one-second wrap of the tick counter. Configuration writes are always
// accepted and must be issued only while no request is in flight.
module rtc_with_periodic_interrupts_top #(
  parameter int CRYSTAL_HZ = rtc_pkg::CRYSTAL_HZ_DEF
) (
  input logic       clk,
  input logic       rst_n,
  rtc_in_if.sink    in_ch,
  rtc_out_if.source out_ch,
  rtc_cfg_if.sink   cfg_ch
);
  import rtc_pkg::*;

  localparam int TICK_W = $clog2(CRYSTAL_HZ);

  // configuration
  logic        clock_enable_r;
  logic [15:0] event_mask_r;

  // input register
  logic        s1_valid_r;
  logic [1:0]  s1_cmd_r;
  logic [15:0] s1_clear_r;
  logic [4:0]  s1_hours_r;
  logic [5:0]  s1_minutes_r;
  logic [5:0]  s1_seconds_r;
  logic [8:0]  s1_days_r;

  // clock state
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [4:0]  hours_r, hours_nxt;
  logic [5:0]  minutes_r, minutes_nxt;
  logic [5:0]  seconds_r, seconds_nxt;
  logic [8:0]  days_r, days_nxt;
  logic [15:0] status_r, status_nxt;
  logic        per_pend_r, per_pend_nxt;
  logic        clk_pend_r, clk_pend_nxt;

  // result register
  logic        out_valid_r;
  logic [15:0] o_status_r;
  logic        o_per_r, o_clk_r;
  logic [4:0]  o_hours_r;
  logic [5:0]  o_minutes_r, o_seconds_r;
  logic [8:0]  o_days_r;

  logic advance;
  logic in_fire;
  logic do_crystal;
  logic tick_wrap;
  logic [NUM_RATES-1:0] rate_hit;

  assign advance    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_fire    = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign do_crystal = s1_valid_r && advance && (rtc_cmd_t'(s1_cmd_r) == CMD_CRYSTAL_TICK);
  assign tick_wrap  = ({1'b0, tick_r} >= (TICK_W+1)'(CRYSTAL_HZ - 1));

  // one phase counter per periodic rate: tracks tick count modulo the period
  for (genvar g = 0; g < NUM_RATES; g++) begin : g_rate
    localparam int DIV = CRYSTAL_HZ / (LOWEST_RATE << g);
    localparam int PW  = (DIV > 1) ? $clog2(DIV) : 1;
    logic [PW-1:0] phase_r, phase_nxt;

    always_comb begin
      if (tick_wrap || phase_r == PW'(DIV - 1)) begin
        phase_nxt = '0;
      end else begin
        phase_nxt = phase_r + PW'(1);
      end
    end

    assign rate_hit[g] = (phase_nxt == '0);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        phase_r <= '0;
      end else if (do_crystal) begin
        phase_r <= phase_nxt;
      end
    end
  end

  always_comb begin
    logic [6:0]  sec_inc;
    logic [6:0]  min_inc;
    logic [5:0]  hour_inc;
    logic [15:0] raised;

    tick_nxt     = tick_r;
    hours_nxt    = hours_r;
    minutes_nxt  = minutes_r;
    seconds_nxt  = seconds_r;
    days_nxt     = days_r;
    status_nxt   = status_r;
    per_pend_nxt = per_pend_r;
    clk_pend_nxt = clk_pend_r;
    sec_inc      = {1'b0, seconds_r} + 7'd1;
    min_inc      = {1'b0, minutes_r} + 7'd1;
    hour_inc     = {1'b0, hours_r} + 6'd1;
    raised       = '0;

    case (rtc_cmd_t'(s1_cmd_r))
      CMD_CRYSTAL_TICK: begin
        tick_nxt = tick_wrap ? '0 : tick_r + TICK_W'(1);
        raised   = {rate_hit, 8'h00} & event_mask_r;
        if (raised != '0) begin
          status_nxt   = status_r | raised;
          per_pend_nxt = 1'b1;
        end
      end
      CMD_SECOND_TICK: begin
        if (clock_enable_r) begin
          raised = FLAG_SECOND;
          if (sec_inc >= 7'(SEC_PER_MIN)) begin
            seconds_nxt = '0;
            raised      = raised | FLAG_MINUTE;
            if (min_inc >= 7'(MIN_PER_HOUR)) begin
              minutes_nxt = '0;
              raised      = raised | FLAG_HOUR;
              if (hour_inc >= 6'(HOURS_PER_DAY)) begin
                hours_nxt = '0;
                days_nxt  = days_r + 9'd1;
                raised    = raised | FLAG_DAY;
              end else begin
                hours_nxt = hour_inc[4:0];
              end
            end else begin
              minutes_nxt = min_inc[5:0];
            end
          end else begin
            seconds_nxt = sec_inc[5:0];
          end
          raised = raised & event_mask_r;
          if (raised != '0) begin
            status_nxt   = status_r | raised;
            clk_pend_nxt = 1'b1;
          end
        end
      end
      CMD_CLEAR_STATUS: begin
        status_nxt = status_r & ~s1_clear_r;
        if ((status_nxt & GROUP_PERIODIC) == '0) per_pend_nxt = 1'b0;
        if ((status_nxt & GROUP_CLOCK) == '0) clk_pend_nxt = 1'b0;
      end
      default: begin
        hours_nxt   = s1_hours_r;
        minutes_nxt = s1_minutes_r;
        seconds_nxt = s1_seconds_r;
        days_nxt    = s1_days_r;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_enable_r <= 1'b1;
      event_mask_r   <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        REG_CLOCK_ENABLE: clock_enable_r <= cfg_ch.data[0];
        REG_EVENT_MASK:   event_mask_r   <= cfg_ch.data & MASK_WRITABLE;
        default: ;
      endcase
    end
  end

  // input register: hold while the result side stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r     <= in_ch.cmd;
      s1_clear_r   <= in_ch.clear_mask;
      s1_hours_r   <= in_ch.new_hours;
      s1_minutes_r <= in_ch.new_minutes;
      s1_seconds_r <= in_ch.new_seconds;
      s1_days_r    <= in_ch.new_days;
    end
  end

  // state advances as the request moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r     <= '0;
      hours_r    <= '0;
      minutes_r  <= '0;
      seconds_r  <= '0;
      days_r     <= '0;
      status_r   <= '0;
      per_pend_r <= 1'b0;
      clk_pend_r <= 1'b0;
    end else if (s1_valid_r && advance) begin
      tick_r     <= tick_nxt;
      hours_r    <= hours_nxt;
      minutes_r  <= minutes_nxt;
      seconds_r  <= seconds_nxt;
      days_r     <= days_nxt;
      status_r   <= status_nxt;
      per_pend_r <= per_pend_nxt;
      clk_pend_r <= clk_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) begin
      o_status_r  <= status_nxt;
      o_per_r     <= per_pend_nxt;
      o_clk_r     <= clk_pend_nxt;
      o_hours_r   <= hours_nxt;
      o_minutes_r <= minutes_nxt;
      o_seconds_r <= seconds_nxt;
      o_days_r    <= days_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_status = o_status_r;
  assign out_ch.periodic_irq = o_per_r;
  assign out_ch.clock_irq    = o_clk_r;
  assign out_ch.hours_now    = o_hours_r;
  assign out_ch.minutes_now  = o_minutes_r;
  assign out_ch.seconds_now  = o_seconds_r;
  assign out_ch.days_now     = o_days_r;

endmodule
